@@ sv/coalesced_hash_table_macros.svh @@
// ----------------------------------------------------------------------------
// Coalesced hash table assertion macros
// Shared concurrent assertion forms for the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef COALESCED_HASH_TABLE_MACROS_SVH
`define COALESCED_HASH_TABLE_MACROS_SVH

// clocked assertion, masked while reset is high
`define CHT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also holds through reset
`define CHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ sv/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// Coalesced hash table package
// Sizes, command and status codes, and shared types of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

  localparam int TABLE_SLOTS = 7;
  localparam int KEY_W       = 31;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  // slot codes reach TABLE_SLOTS itself, which marks "no successor"
  localparam int SLOT_W      = $clog2(TABLE_SLOTS + 1);
  localparam logic [SLOT_W-1:0] NO_NEXT = SLOT_W'(TABLE_SLOTS);

  // home slot = key mod TABLE_SLOTS through a reciprocal multiply
  localparam int RECIP_SH = KEY_W + $clog2(TABLE_SLOTS);
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RECIP_SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam int RECIP_W = KEY_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
  localparam int PROD_W = KEY_W + RECIP_W;

  localparam int IN_DW  = ((KEY_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_DW = ((SLOT_W + DATA_W + 7) / 8) * 8;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } cht_item_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
  } cht_res_t;

endpackage

`default_nettype wire

@@ sv/coalesced_hash_table.sv @@
// ----------------------------------------------------------------------------
// Coalesced hash table
// Search / insert / remove over a table with internal chaining.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)             tuser
// s_*      in   key[30:0], entry_data[62:31]   command[1:0]
// m_*      out  slot[2:0], read_data[34:3]     status[1:0]
//
// Per item: multiply, remainder and start; the walk then reads each slot on
// the chain (up to 7) before decide, and an insert that links a fresh slot
// adds a link step. An empty home slot or an unknown command ends at start.
// The chain walk reads one slot per cycle from the slot RAMs; the next
// address comes straight from the successor field just read.
// Reset clears the used/deleted flag registers directly; no clearing pass.
// A result waits in its own register; a stalled m_tready holds the next
// item back only once that register is full and a new result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coalesced_hash_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [cht_pkg::IN_DW-1:0]   s_tdata,  // key, entry_data, zero pad
  input  wire logic [1:0]                  s_tuser,  // command
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [cht_pkg::OUT_DW-1:0]  m_tdata,  // slot, read_data, zero pad
  output logic      [1:0]                  m_tuser   // status
);

  localparam int KW = cht_pkg::KEY_W;
  localparam int DW = cht_pkg::DATA_W;
  localparam int SW = cht_pkg::SLOT_W;

  cht_pkg::cht_item_t item;
  cht_pkg::cht_res_t  res;
  logic               res_ready;

  logic [1:0]    out_status;
  logic [SW-1:0] out_slot;
  logic [DW-1:0] out_data;

  always_comb begin
    item.cmd  = s_tuser;
    item.key  = s_tdata[KW-1:0];
    item.data = s_tdata[KW+DW-1:KW];
  end

  cht_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register: loads a result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status <= res.status;
      out_slot   <= res.slot;
      out_data   <= res.data;
    end
  end

  assign m_tdata = cht_pkg::OUT_DW'({out_data, out_slot});
  assign m_tuser = out_status;

endmodule

`default_nettype wire

@@ sv/cht_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/cht_engine.sv @@
// ----------------------------------------------------------------------------
// Coalesced hash table engine
// Home slot remainder, chain walk over the slot RAMs, insert/remove updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "coalesced_hash_table_macros.svh"

module cht_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cht_pkg::cht_item_t item,
  output cht_pkg::cht_res_t       res,
  input  wire logic               res_ready
);

  localparam int N  = cht_pkg::TABLE_SLOTS;
  localparam int SW = cht_pkg::SLOT_W;
  localparam int IW = cht_pkg::IDX_W;
  localparam int KW = cht_pkg::KEY_W;
  localparam int DW = cht_pkg::DATA_W;
  localparam logic [SW-1:0] NSLOT = SW'(N);
  localparam logic [SW-1:0] NO_NEXT_C = cht_pkg::NO_NEXT;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_REM    = 7'b0000100,
    S_START  = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_LINK   = 7'b1000000
  } state_t;

  // result holding register state
  typedef enum logic [1:0] {
    R_EMPTY = 2'b01,
    R_FULL  = 2'b10
  } res_state_t;

  state_t     state;
  res_state_t rstate;

  logic [1:0]                 cmd;
  logic [KW-1:0]              key;
  logic [DW-1:0]              data;
  logic [cht_pkg::PROD_W-1:0] prod;
  logic [SW-1:0]              home;
  logic [SW-1:0]              cur;
  logic [SW-1:0]              tail;
  logic [SW-1:0]              steps;
  logic [SW-1:0]              live;
  logic [SW-1:0]              dead_same;
  logic [SW-1:0]              dead_first;
  logic [SW-1:0]              free_reg;
  logic [DW-1:0]              live_data;
  logic [N-1:0]               used;
  logic [N-1:0]               deleted;
  logic [1:0]                 res_status;
  logic [SW-1:0]              res_slot;
  logic [DW-1:0]              res_data;

  // slot RAM ports
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [KW+DW-1:0] kp_rdata;
  logic [SW-1:0]    nx_rdata;
  logic             kp_we;
  logic [IW-1:0]    kp_waddr;
  logic             nx_we;
  logic [IW-1:0]    nx_waddr;
  logic [SW-1:0]    nx_wdata;

  cht_ram #(.WIDTH(KW + DW), .DEPTH(N)) u_kp_ram (
    .clk   (clk),
    .we    (kp_we),
    .waddr (kp_waddr),
    .wdata ({key, data}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (kp_rdata)
  );

  cht_ram #(.WIDTH(SW), .DEPTH(N)) u_nx_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (nx_rdata)
  );

  // remainder from the registered reciprocal product
  logic [KW-1:0] quot;
  logic [KW-1:0] rem_raw;
  logic [KW-1:0] rem_fix;

  always_comb begin
    quot    = KW'(prod >> cht_pkg::RECIP_SH);
    rem_raw = key - KW'(quot * KW'(N));
    rem_fix = (rem_raw >= KW'(N)) ? (rem_raw - KW'(N)) : rem_raw;
  end

  // chain walk step
  logic [KW-1:0] rd_key;
  logic [DW-1:0] rd_pay;
  logic [IW-1:0] cur_idx;
  logic [IW-1:0] home_idx;
  logic          hit;
  logic [SW-1:0] steps_inc;
  logic          walk_more;
  logic          cmd_ok;

  always_comb begin
    rd_key    = kp_rdata[KW+DW-1:DW];
    rd_pay    = kp_rdata[DW-1:0];
    cur_idx   = cur[IW-1:0];
    home_idx  = home[IW-1:0];
    hit       = used[cur_idx] && (rd_key == key);
    steps_inc = steps + SW'(1);
    walk_more = (steps_inc < NSLOT) && (nx_rdata < NSLOT);
    cmd_ok    = (cmd == cht_pkg::CMD_SEARCH) || (cmd == cht_pkg::CMD_INSERT) ||
                (cmd == cht_pkg::CMD_REMOVE);
  end

  // lowest never-used slot
  logic          free_found;
  logic [SW-1:0] free_slot;

  always_comb begin
    free_found = 1'b0;
    free_slot  = NO_NEXT_C;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  logic          reuse;
  logic [SW-1:0] reuse_slot;
  logic          home_fill;

  always_comb begin
    reuse      = (dead_same != NO_NEXT_C) || (dead_first != NO_NEXT_C);
    reuse_slot = (dead_same != NO_NEXT_C) ? dead_same : dead_first;
    home_fill  = (state == S_START) && (cmd == cht_pkg::CMD_INSERT) && !used[home_idx];
  end

  // RAM control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = home_idx;
    kp_we    = 1'b0;
    kp_waddr = home_idx;
    nx_we    = 1'b0;
    nx_waddr = home_idx;
    nx_wdata = NO_NEXT_C;
    unique case (state)
      S_START: begin
        rd_en = cmd_ok && used[home_idx];
        if (home_fill) begin
          kp_we = 1'b1;
          nx_we = 1'b1;
        end
      end
      S_WALK: begin
        rd_en   = walk_more;
        rd_addr = nx_rdata[IW-1:0];
      end
      S_DECIDE: begin
        if ((cmd == cht_pkg::CMD_INSERT) && (live == NO_NEXT_C)) begin
          if (reuse) begin
            kp_we    = 1'b1;
            kp_waddr = reuse_slot[IW-1:0];
          end else if (free_found) begin
            kp_we    = 1'b1;
            kp_waddr = free_slot[IW-1:0];
            nx_we    = 1'b1;
            nx_waddr = free_slot[IW-1:0];
          end
        end
      end
      S_LINK: begin
        nx_we    = 1'b1;
        nx_waddr = tail[IW-1:0];
        nx_wdata = free_reg;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE) && (rstate == R_EMPTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rstate  <= R_EMPTY;
      used    <= '0;
      deleted <= '0;
    end else begin
      if ((rstate == R_FULL) && res_ready) begin
        rstate <= R_EMPTY;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd   <= item.cmd;
            key   <= item.key;
            data  <= item.data;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= cht_pkg::PROD_W'(key) * cht_pkg::PROD_W'(cht_pkg::RECIP);
          state <= S_REM;
        end
        S_REM: begin
          home  <= SW'(rem_fix);
          state <= S_START;
        end
        S_START: begin
          live       <= NO_NEXT_C;
          dead_same  <= NO_NEXT_C;
          dead_first <= NO_NEXT_C;
          live_data  <= '0;
          steps      <= '0;
          cur        <= home;
          tail       <= home;
          res_slot   <= '0;
          res_data   <= '0;
          res_status <= cht_pkg::ST_MISSING;
          if (!cmd_ok) begin
            rstate <= R_FULL;
            state  <= S_IDLE;
          end else if (!used[home_idx]) begin
            if (home_fill) begin
              used[home_idx]    <= 1'b1;
              deleted[home_idx] <= 1'b0;
              res_status        <= cht_pkg::ST_DONE;
              res_slot          <= home;
            end
            rstate <= R_FULL;
            state  <= S_IDLE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          tail  <= cur;
          steps <= steps_inc;
          if (used[cur_idx] && deleted[cur_idx]) begin
            if (dead_first == NO_NEXT_C) begin
              dead_first <= cur;
            end
            if (hit && (dead_same == NO_NEXT_C)) begin
              dead_same <= cur;
            end
          end else if (hit && (live == NO_NEXT_C)) begin
            live      <= cur;
            live_data <= rd_pay;
          end
          if (walk_more) begin
            cur <= nx_rdata;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_status <= cht_pkg::ST_MISSING;
          res_slot   <= '0;
          res_data   <= '0;
          rstate     <= R_FULL;
          state      <= S_IDLE;
          if (cmd == cht_pkg::CMD_SEARCH) begin
            if (live != NO_NEXT_C) begin
              res_status <= cht_pkg::ST_DONE;
              res_slot   <= live;
              res_data   <= live_data;
            end
          end else if (cmd == cht_pkg::CMD_REMOVE) begin
            if (live != NO_NEXT_C) begin
              deleted[live[IW-1:0]] <= 1'b1;
              res_status            <= cht_pkg::ST_DONE;
              res_slot              <= live;
            end
          end else if (live != NO_NEXT_C) begin
            res_status <= cht_pkg::ST_DUP;
          end else if (reuse) begin
            used[reuse_slot[IW-1:0]]    <= 1'b1;
            deleted[reuse_slot[IW-1:0]] <= 1'b0;
            res_status                  <= cht_pkg::ST_DONE;
            res_slot                    <= reuse_slot;
          end else if (free_found) begin
            used[free_slot[IW-1:0]]    <= 1'b1;
            deleted[free_slot[IW-1:0]] <= 1'b0;
            free_reg                   <= free_slot;
            res_status                 <= cht_pkg::ST_DONE;
            res_slot                   <= free_slot;
            rstate                     <= R_EMPTY;
            state                      <= S_LINK;
          end else begin
            res_status <= cht_pkg::ST_FULL;
          end
        end
        S_LINK: begin
          rstate <= R_FULL;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.valid  = (rstate == R_FULL);
    res.status = res_status;
    res.slot   = res_slot;
    res.data   = res_data;
  end

  `CHT_ASSERT(a_accept_starts, clk, rst, (in_valid && in_ready) |=> (state == S_MUL), "accepted item did not start")
  `CHT_ASSERT(a_slot_zero, clk, rst, (res.valid && (res.status != cht_pkg::ST_DONE)) |-> (res.slot == '0), "slot not zero on failure")
  `CHT_ASSERT(a_data_search, clk, rst, (res.valid && (res.data != '0)) |-> ((res.status == cht_pkg::ST_DONE) && (cmd == cht_pkg::CMD_SEARCH)), "read data outside found search")
  `CHT_ASSERT(a_link_used, clk, rst, (state == S_LINK) |-> used[free_reg[IW-1:0]], "linked slot not marked used")
  `CHT_ASSERT_ALWAYS(a_walk_bound, clk, (state == S_WALK) |-> (steps < NSLOT), "chain walk ran past table size")

endmodule

`default_nettype wire

@@ sim/cht_result_checker.sv @@
// ----------------------------------------------------------------------------
// Coalesced hash table result checker
// Watches both stream channels. Every accepted command runs through a
// local copy of the slot table to give the expected reply. Every
// accepted reply is checked field by field against the oldest expected
// reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [cht_pkg::IN_DW-1:0]  s_tdata,   // key, entry_data, zero pad
  input  logic [1:0]                 s_tuser,   // command
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [cht_pkg::OUT_DW-1:0] m_tdata,   // slot, read_data, zero pad
  input  logic [1:0]                 m_tuser,   // status
  output int                         fail_count,
  output int                         pending
);

  localparam int TABLE_SLOTS = cht_pkg::TABLE_SLOTS;
  localparam int KEY_W       = cht_pkg::KEY_W;
  localparam int DATA_W      = cht_pkg::DATA_W;
  localparam int SLOT_W      = cht_pkg::SLOT_W;
  localparam int NONE        = TABLE_SLOTS;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
  } table_reply_t;

  logic [KEY_W-1:0]  key_mem     [TABLE_SLOTS];
  logic [DATA_W-1:0] payload_mem [TABLE_SLOTS];
  logic [SLOT_W-1:0] link_mem    [TABLE_SLOTS];
  logic              used_mem    [TABLE_SLOTS];
  logic              gone_mem    [TABLE_SLOTS];

  table_reply_t replies_due[$];

  function automatic void store_entry(int s, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data);
    key_mem[s]     = key;
    payload_mem[s] = data;
    used_mem[s]    = 1'b1;
    gone_mem[s]    = 1'b0;
  endfunction

  // applies one command to the local table and returns the reply it gives
  function automatic table_reply_t apply_table_op(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                                  logic [DATA_W-1:0] data);
    table_reply_t r;
    int home, cur, tail, live, dead_same, dead_first, fresh;
    r.status   = cht_pkg::ST_MISSING;
    r.slot     = '0;
    r.data     = '0;
    home       = int'(key % KEY_W'(TABLE_SLOTS));
    live       = NONE;
    dead_same  = NONE;
    dead_first = NONE;
    if (cmd != cht_pkg::CMD_SEARCH && cmd != cht_pkg::CMD_INSERT &&
        cmd != cht_pkg::CMD_REMOVE) return r;
    if (!used_mem[home]) begin
      if (cmd == cht_pkg::CMD_INSERT) begin
        store_entry(home, key, data);
        r.status = cht_pkg::ST_DONE;
        r.slot   = SLOT_W'(home);
      end
      return r;
    end
    cur  = home;
    tail = home;
    for (int steps = 0; steps < TABLE_SLOTS && cur < TABLE_SLOTS; steps++) begin
      tail = cur;
      if (used_mem[cur]) begin
        if (gone_mem[cur]) begin
          if (dead_first == NONE) dead_first = cur;
          if (key_mem[cur] == key && dead_same == NONE) dead_same = cur;
        end else if (key_mem[cur] == key && live == NONE) begin
          live = cur;
        end
      end
      cur = int'(link_mem[cur]);
    end
    case (cmd)
      cht_pkg::CMD_SEARCH: begin
        if (live != NONE) begin
          r.status = cht_pkg::ST_DONE;
          r.slot   = SLOT_W'(live);
          r.data   = payload_mem[live];
        end
      end
      cht_pkg::CMD_REMOVE: begin
        if (live != NONE) begin
          gone_mem[live] = 1'b1;
          r.status = cht_pkg::ST_DONE;
          r.slot   = SLOT_W'(live);
        end
      end
      default: begin
        if (live != NONE) begin
          r.status = cht_pkg::ST_DUP;
        end else if (dead_same != NONE || dead_first != NONE) begin
          // a deleted copy of the same key wins over the first deleted slot
          fresh = (dead_same != NONE) ? dead_same : dead_first;
          store_entry(fresh, key, data);
          r.status = cht_pkg::ST_DONE;
          r.slot   = SLOT_W'(fresh);
        end else begin
          fresh = NONE;
          for (int i = TABLE_SLOTS - 1; i >= 0; i--)
            if (!used_mem[i]) fresh = i;
          if (fresh == NONE) begin
            r.status = cht_pkg::ST_FULL;
          end else begin
            store_entry(fresh, key, data);
            link_mem[fresh] = cht_pkg::NO_NEXT;
            link_mem[tail]  = SLOT_W'(fresh);
            r.status = cht_pkg::ST_DONE;
            r.slot   = SLOT_W'(fresh);
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    logic [SLOT_W-1:0] got_slot;
    logic [DATA_W-1:0] got_data;
    int errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        link_mem[i] = cht_pkg::NO_NEXT;
        used_mem[i] = 1'b0;
        gone_mem[i] = 1'b0;
      end
      replies_due.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // a reply always belongs to an earlier command, so pop before push
      if (m_tvalid && m_tready) begin
        got_slot = m_tdata[SLOT_W-1:0];
        got_data = m_tdata[SLOT_W +: DATA_W];
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none expected, status %0d slot %0d data %h",
                   $time, m_tuser, got_slot, got_data);
          errs++;
        end else begin
          want = replies_due.pop_front();
          if (m_tuser !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_tuser);
            errs++;
          end
          if (got_slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, got_slot);
            errs++;
          end
          if (got_data !== want.data) begin
            $display("%0t: read_data mismatch, expected %h, actual %h",
                     $time, want.data, got_data);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready)
        replies_due.push_back(apply_table_op(s_tuser, s_tdata[KEY_W-1:0],
                                             s_tdata[KEY_W +: DATA_W]));
      fail_count <= fail_count + errs;
      pending    <= replies_due.size();
    end
  end

endmodule

@@ sim/tb_coalesced_hash_table.sv @@
// ----------------------------------------------------------------------------
// Coalesced hash table testbench
// A short directed pass over empty, chained, deleted and full tables, then
// random commands over a small key pool, with random gaps and stalls on
// both channels. Replies are checked by cht_result_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coalesced_hash_table;

  localparam int         KEY_W        = cht_pkg::KEY_W;
  localparam int         DATA_W       = cht_pkg::DATA_W;
  localparam int         IN_DW        = cht_pkg::IN_DW;
  localparam int         OUT_DW       = cht_pkg::OUT_DW;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         RANDOM_ITEMS = 1600;
  localparam int         POOL_SIZE    = 10;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata  = '0;
  logic [1:0]        s_tuser  = cht_pkg::CMD_SEARCH;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic [1:0]        m_tuser;

  int fail_count;
  int pending;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  coalesced_hash_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  cht_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // hold commands back until every reply is in; first edge lets pending settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_op(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                         input logic [DATA_W-1:0] data);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DW'({data, key});
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 48 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int pick;
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty home slot, then a chain grown from slot 0
    send_op(cht_pkg::CMD_SEARCH, 31'd0, 32'h0000_0000);
    send_op(cht_pkg::CMD_REMOVE, 31'd5, 32'hFFFF_FFFF);
    send_op(cht_pkg::CMD_INSERT, 31'd0, 32'hFFFF_FFFF);
    send_op(cht_pkg::CMD_INSERT, 31'd0, 32'h0000_0000);   // live duplicate
    send_op(cht_pkg::CMD_INSERT, 31'd7, 32'h1234_5678);
    send_op(cht_pkg::CMD_INSERT, 31'd14, 32'h0000_0000);
    send_op(cht_pkg::CMD_SEARCH, 31'd7, 32'h0000_0000);
    send_op(cht_pkg::CMD_SEARCH, 31'd0, 32'h0000_0000);
    // removal and reuse of deleted slots
    send_op(cht_pkg::CMD_REMOVE, 31'd7, 32'h0000_0000);
    send_op(cht_pkg::CMD_SEARCH, 31'd7, 32'h0000_0000);
    send_op(cht_pkg::CMD_REMOVE, 31'd7, 32'h0000_0000);
    send_op(cht_pkg::CMD_REMOVE, 31'd14, 32'h0000_0000);
    send_op(cht_pkg::CMD_INSERT, 31'd21, 32'h5555_5555);  // first deleted slot
    send_op(cht_pkg::CMD_INSERT, 31'd14, 32'hAAAA_AAAA);  // deleted copy of same key
    // other homes taken over by the chain, until the table is full
    send_op(cht_pkg::CMD_INSERT, 31'h7FFF_FFFF, 32'hAAAA_AAAA);
    send_op(cht_pkg::CMD_INSERT, 31'd3, 32'h0F0F_0F0F);
    send_op(cht_pkg::CMD_SEARCH, 31'd3, 32'h0000_0000);
    send_op(cht_pkg::CMD_INSERT, 31'd4, 32'hF0F0_F0F0);
    send_op(cht_pkg::CMD_INSERT, 31'd28, 32'h0000_0001);
    send_op(cht_pkg::CMD_INSERT, 31'd35, 32'h8000_0000);
    send_op(CMD_UNKNOWN, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(cht_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 32'h0000_0000);
    send_op(cht_pkg::CMD_REMOVE, 31'd0, 32'h0000_0000);
    send_op(cht_pkg::CMD_INSERT, 31'd42, 32'hDEAD_BEEF);
    wait_drained();

    // inserts stay on the pool so the table keeps turning over
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35)      cmd = cht_pkg::CMD_SEARCH;
      else if (pick < 70) cmd = cht_pkg::CMD_INSERT;
      else if (pick < 95) cmd = cht_pkg::CMD_REMOVE;
      else                cmd = CMD_UNKNOWN;
      if (cmd != cht_pkg::CMD_INSERT && $urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_op(cmd, key, $urandom);
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
    wait_drained();
    repeat (40) @(posedge clk);

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
